// ===== hdl/cpjr_pkg.sv =====
// Shared types and constants for the cascaded PI joint regulator.
// No dependencies; every other file of the block imports this package.
package cpjr_pkg;

  // Q16.16 number format
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned PROD_W  = 2 * VALUE_W;

  // Unsigned fields: time step and integral caps
  localparam int unsigned UFIELD_W = 31;

  // Action bits and configuration port
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_POS_KP  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_POS_KI  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SPD_KP  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPD_KI  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_POS_CAP = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SPD_CAP = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_FF_GAIN = 3'd6;

  // Action bit positions
  localparam int unsigned ACT_RAMP    = 0;
  localparam int unsigned ACT_POS_ON  = 1;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [UFIELD_W-1:0]       ufield_t;

  // Operands for the shared arithmetic unit
  typedef struct packed {
    value_t mul_a;
    value_t mul_b;
    value_t add_a;
    value_t add_b;
    logic   sub;
  } alu_req_t;

  // Saturated results of the shared arithmetic unit
  typedef struct packed {
    value_t prod;
    value_t sum;
  } alu_rsp_t;

endpackage

// ===== hdl/cascaded_pi_joint_regulator.sv =====
// Cascaded PI regulator for one joint: position loop feeding a speed loop.
// Depends on cpjr_pkg and cpjr_alu.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one item per control step:
//   time step, measured position and speed, targets and loop flags.
//   Output channel (out_valid_o / out_ready_i) returns one item per input:
//   the drive force and the two integral clamp flags.
//   Gains and caps are written through cfg_we_i / cfg_index_i / cfg_wdata_i
//   while the block is idle; writes to an unknown index are ignored.
// Timing:
//   All arithmetic goes through one shared multiplier and one saturating
//   adder, stepped by a sequencer, one operation per cycle except while it
//   holds in its final step. An item runs the speed loop steps, after the
//   ramp steps if it ramps and the position loop steps if that loop is on.
//   The next item is taken once the sequencer is back in idle.
//   in_ready_o is high only while the sequencer is idle.
// Stall:
//   The result sits in an output register. A new item is accepted while it
//   waits; the sequencer holds in its final step until the register frees.
// Reset:
//   Gains and caps go to their defaults, all loop state to zero, no result
//   pending. The clear bit of an item zeroes the loop state as well.
module cascaded_pi_joint_regulator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [cpjr_pkg::REG_IDX_W-1:0]      cfg_index_i,
  input  logic [cpjr_pkg::VALUE_W-1:0]        cfg_wdata_i,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [cpjr_pkg::UFIELD_W-1:0]       time_step_i,
  input  logic signed [cpjr_pkg::VALUE_W-1:0] measured_position_i,
  input  logic signed [cpjr_pkg::VALUE_W-1:0] measured_speed_i,
  input  logic [cpjr_pkg::ACTION_W-1:0]       action_i,
  input  logic                                load_target_i,
  input  logic signed [cpjr_pkg::VALUE_W-1:0] new_position_target_i,
  input  logic signed [cpjr_pkg::VALUE_W-1:0] ramp_rate_i,
  input  logic signed [cpjr_pkg::VALUE_W-1:0] speed_command_i,
  input  logic                                clear_i,
  // result items
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [cpjr_pkg::VALUE_W-1:0] drive_force_o,
  output logic                                position_clamped_o,
  output logic                                speed_clamped_o
);
  import cpjr_pkg::*;

  // Sequencer steps
  localparam int unsigned ST_W = 5;
  localparam logic [ST_W-1:0] ST_IDLE    = 5'd0;
  localparam logic [ST_W-1:0] ST_RAMP_M  = 5'd1;
  localparam logic [ST_W-1:0] ST_RAMP_A  = 5'd2;
  localparam logic [ST_W-1:0] ST_PERR    = 5'd3;
  localparam logic [ST_W-1:0] ST_PINT_M  = 5'd4;
  localparam logic [ST_W-1:0] ST_PINT_A  = 5'd5;
  localparam logic [ST_W-1:0] ST_PINT_C  = 5'd6;
  localparam logic [ST_W-1:0] ST_PKP_M   = 5'd7;
  localparam logic [ST_W-1:0] ST_PKI_M   = 5'd8;
  localparam logic [ST_W-1:0] ST_FFG_M   = 5'd9;
  localparam logic [ST_W-1:0] ST_SPT_A   = 5'd10;
  localparam logic [ST_W-1:0] ST_SERR    = 5'd11;
  localparam logic [ST_W-1:0] ST_SINT_M  = 5'd12;
  localparam logic [ST_W-1:0] ST_SINT_A  = 5'd13;
  localparam logic [ST_W-1:0] ST_SINT_C  = 5'd14;
  localparam logic [ST_W-1:0] ST_SKP_M   = 5'd15;
  localparam logic [ST_W-1:0] ST_SKI_M   = 5'd16;
  localparam logic [ST_W-1:0] ST_FORCE_A = 5'd17;

  localparam value_t ONE_Q16 = value_t'(1) <<< FRAC_W;

  logic [ST_W-1:0] state_q, state_d;

  // configuration registers
  value_t  pos_kp_q, pos_ki_q, spd_kp_q, spd_ki_q, ff_gain_q;
  ufield_t pos_cap_q, spd_cap_q;

  // loop state
  value_t tgt_q, psum_q, ssum_q, lforce_q, spdtgt_q;

  // latched item and scratch
  ufield_t               dt_q;
  value_t                pos_q, spd_q, rate_q;
  logic [ACTION_W-1:0]   act_q;
  value_t                err_q, acc_q, prod_q;
  logic                  pflag_q, sflag_q;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  value_t dt_v, pcap_v, scap_v;
  logic   in_fire, out_free;
  logic   p_hi, p_lo, s_hi, s_lo;

  assign dt_v   = value_t'({1'b0, dt_q});
  assign pcap_v = value_t'({1'b0, pos_cap_q});
  assign scap_v = value_t'({1'b0, spd_cap_q});

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_o || out_ready_i;

  // clamp compares against the symmetric caps
  assign p_hi = psum_q > pcap_v;
  assign p_lo = psum_q < -pcap_v;
  assign s_hi = ssum_q > scap_v;
  assign s_lo = ssum_q < -scap_v;

  cpjr_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // operand selection for the shared unit
  always_comb begin
    alu_req = '0;
    unique case (state_q)
      ST_RAMP_M: begin
        alu_req.mul_a = rate_q;
        alu_req.mul_b = dt_v;
      end
      ST_RAMP_A: begin
        alu_req.add_a = tgt_q;
        alu_req.add_b = prod_q;
      end
      ST_PERR: begin
        alu_req.add_a = tgt_q;
        alu_req.add_b = pos_q;
        alu_req.sub   = 1'b1;
      end
      ST_PINT_M, ST_SINT_M: begin
        alu_req.mul_a = err_q;
        alu_req.mul_b = dt_v;
      end
      ST_PINT_A: begin
        alu_req.add_a = psum_q;
        alu_req.add_b = prod_q;
      end
      ST_PKP_M: begin
        alu_req.mul_a = pos_kp_q;
        alu_req.mul_b = err_q;
      end
      ST_PKI_M: begin
        alu_req.mul_a = pos_ki_q;
        alu_req.mul_b = psum_q;
      end
      ST_FFG_M: begin
        alu_req.mul_a = lforce_q;
        alu_req.mul_b = ff_gain_q;
        alu_req.add_a = acc_q;
        alu_req.add_b = prod_q;
      end
      ST_SPT_A: begin
        alu_req.add_a = acc_q;
        alu_req.add_b = prod_q;
        alu_req.sub   = 1'b1;
      end
      ST_SERR: begin
        alu_req.add_a = spdtgt_q;
        alu_req.add_b = spd_q;
        alu_req.sub   = 1'b1;
      end
      ST_SINT_A: begin
        alu_req.add_a = ssum_q;
        alu_req.add_b = prod_q;
      end
      ST_SKP_M: begin
        alu_req.mul_a = spd_kp_q;
        alu_req.mul_b = err_q;
      end
      ST_SKI_M: begin
        alu_req.mul_a = spd_ki_q;
        alu_req.mul_b = ssum_q;
      end
      ST_FORCE_A: begin
        alu_req.add_a = acc_q;
        alu_req.add_b = prod_q;
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  // next step
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (action_i[ACT_RAMP]) begin
            state_d = ST_RAMP_M;
          end else if (action_i[ACT_POS_ON]) begin
            state_d = ST_PERR;
          end else begin
            state_d = ST_SERR;
          end
        end
      end
      ST_RAMP_M: state_d = ST_RAMP_A;
      ST_RAMP_A: state_d = act_q[ACT_POS_ON] ? ST_PERR : ST_SERR;
      ST_PERR:   state_d = ST_PINT_M;
      ST_PINT_M: state_d = ST_PINT_A;
      ST_PINT_A: state_d = ST_PINT_C;
      ST_PINT_C: state_d = ST_PKP_M;
      ST_PKP_M:  state_d = ST_PKI_M;
      ST_PKI_M:  state_d = ST_FFG_M;
      ST_FFG_M:  state_d = ST_SPT_A;
      ST_SPT_A:  state_d = ST_SERR;
      ST_SERR:   state_d = ST_SINT_M;
      ST_SINT_M: state_d = ST_SINT_A;
      ST_SINT_A: state_d = ST_SINT_C;
      ST_SINT_C: state_d = ST_SKP_M;
      ST_SKP_M:  state_d = ST_SKI_M;
      ST_SKI_M:  state_d = ST_FORCE_A;
      ST_FORCE_A: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_kp_q  <= ONE_Q16;
      pos_ki_q  <= '0;
      spd_kp_q  <= ONE_Q16;
      spd_ki_q  <= '0;
      pos_cap_q <= '1;
      spd_cap_q <= '0;
      ff_gain_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_POS_KP:  pos_kp_q  <= cfg_wdata_i;
          REG_POS_KI:  pos_ki_q  <= cfg_wdata_i;
          REG_SPD_KP:  spd_kp_q  <= cfg_wdata_i;
          REG_SPD_KI:  spd_ki_q  <= cfg_wdata_i;
          REG_POS_CAP: pos_cap_q <= cfg_wdata_i[UFIELD_W-1:0];
          REG_SPD_CAP: spd_cap_q <= cfg_wdata_i[UFIELD_W-1:0];
          REG_FF_GAIN: ff_gain_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // loop state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q       <= '0;
      psum_q      <= '0;
      ssum_q      <= '0;
      lforce_q    <= '0;
      spdtgt_q    <= '0;
      out_valid_o <= 1'b0;
    end else begin
      // the final step reloads the result register when it frees
      if (out_valid_o && out_ready_i && (state_q != ST_FORCE_A)) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (clear_i) begin
              psum_q   <= '0;
              ssum_q   <= '0;
              lforce_q <= '0;
            end
            if (load_target_i) begin
              tgt_q <= new_position_target_i;
            end else if (clear_i) begin
              tgt_q <= '0;
            end
            if (!action_i[ACT_POS_ON]) begin
              spdtgt_q <= speed_command_i;
            end else if (clear_i) begin
              spdtgt_q <= '0;
            end
          end
        end
        ST_RAMP_A: tgt_q    <= alu_rsp.sum;
        ST_PINT_A: psum_q   <= alu_rsp.sum;
        ST_PINT_C: begin
          if (p_hi) begin
            psum_q <= pcap_v;
          end else if (p_lo) begin
            psum_q <= -pcap_v;
          end
        end
        ST_SPT_A:  spdtgt_q <= alu_rsp.sum;
        ST_SINT_A: ssum_q   <= alu_rsp.sum;
        ST_SINT_C: begin
          if (spd_cap_q != '0) begin
            if (s_hi) begin
              ssum_q <= scap_v;
            end else if (s_lo) begin
              ssum_q <= -scap_v;
            end
          end
        end
        ST_FORCE_A: begin
          if (out_free) begin
            lforce_q    <= alu_rsp.sum;
            out_valid_o <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath scratch, latched item fields and result payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          dt_q    <= time_step_i;
          pos_q   <= measured_position_i;
          spd_q   <= measured_speed_i;
          rate_q  <= ramp_rate_i;
          act_q   <= action_i;
          pflag_q <= 1'b0;
          sflag_q <= 1'b0;
        end
      end
      ST_RAMP_M, ST_PINT_M, ST_PKP_M, ST_SINT_M, ST_SKP_M: begin
        prod_q <= alu_rsp.prod;
      end
      ST_PERR, ST_SERR: begin
        err_q <= alu_rsp.sum;
      end
      ST_PINT_C: begin
        pflag_q <= p_hi || p_lo;
      end
      ST_SINT_C: begin
        sflag_q <= (spd_cap_q != '0) && (s_hi || s_lo);
      end
      ST_PKI_M, ST_SKI_M: begin
        acc_q  <= prod_q;
        prod_q <= alu_rsp.prod;
      end
      ST_FFG_M: begin
        acc_q  <= alu_rsp.sum;
        prod_q <= alu_rsp.prod;
      end
      ST_FORCE_A: begin
        if (out_free) begin
          drive_force_o      <= alu_rsp.sum;
          position_clamped_o <= pflag_q;
          speed_clamped_o    <= sflag_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/cpjr_alu.sv =====
// Shared arithmetic unit: one saturating Q16.16 multiplier and one
// saturating adder/subtractor. Depends on cpjr_pkg.
module cpjr_alu (
  input  cpjr_pkg::alu_req_t req_i,
  output cpjr_pkg::alu_rsp_t rsp_o
);
  import cpjr_pkg::*;

  localparam int unsigned SHR_W = PROD_W - FRAC_W;

  logic signed [PROD_W-1:0] prod_full;
  logic signed [PROD_W-1:0] prod_adj;
  logic signed [SHR_W-1:0]  prod_shr;
  logic [SHR_W-VALUE_W:0]   prod_hi;
  logic                     prod_ovf;

  logic signed [VALUE_W:0]  add_a_x;
  logic signed [VALUE_W:0]  add_b_x;
  logic signed [VALUE_W:0]  sum_x;
  logic                     sum_ovf;

  // Full product, then shift toward zero by the fraction width
  assign prod_full = $signed(req_i.mul_a) * $signed(req_i.mul_b);
  assign prod_adj  = prod_full[PROD_W-1]
                   ? prod_full + $signed({{(PROD_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}})
                   : prod_full;
  assign prod_shr  = prod_adj[PROD_W-1:FRAC_W];

  // Saturate the shifted product to the value range
  assign prod_hi  = prod_shr[SHR_W-1:VALUE_W-1];
  assign prod_ovf = !((&prod_hi) || !(|prod_hi));

  always_comb begin
    if (prod_ovf) begin
      rsp_o.prod = prod_shr[SHR_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                     : {1'b0, {(VALUE_W-1){1'b1}}};
    end else begin
      rsp_o.prod = prod_shr[VALUE_W-1:0];
    end
  end

  // One extra bit for the exact sum or difference
  assign add_a_x = {req_i.add_a[VALUE_W-1], req_i.add_a};
  assign add_b_x = req_i.sub ? -$signed({req_i.add_b[VALUE_W-1], req_i.add_b})
                             :  $signed({req_i.add_b[VALUE_W-1], req_i.add_b});
  assign sum_x   = add_a_x + add_b_x;
  assign sum_ovf = sum_x[VALUE_W] != sum_x[VALUE_W-1];

  always_comb begin
    if (sum_ovf) begin
      rsp_o.sum = sum_x[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                 : {1'b0, {(VALUE_W-1){1'b1}}};
    end else begin
      rsp_o.sum = sum_x[VALUE_W-1:0];
    end
  end

endmodule

// ===== hdl/cpjr_checker.sv =====
// Port-level checks for the cascaded PI joint regulator, bound to the top.
// Depends on cascaded_pi_joint_regulator and cpjr_pkg.
module cpjr_assertions (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [cpjr_pkg::VALUE_W-1:0] drive_force_o
);
  import cpjr_pkg::*;

  // an accepted item keeps the block busy, with in_ready_o low after the accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o)
    else $error("input taken again too soon after an item");

  // a fresh result only appears at the end of a busy sequence
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without work in progress");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(drive_force_o)))
    else $error("stalled result dropped or changed");

  // no result is pending once reset has been seen
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result pending during reset");

endmodule

bind cascaded_pi_joint_regulator cpjr_assertions u_cpjr_assertions (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .drive_force_o (drive_force_o)
);

// ===== verif/cpjr_checker.sv =====
// Scoreboard for the cascaded PI joint regulator: watches config writes and both item channels.
// Keeps its own copy of gains, caps and loop state, predicts each result and compares it.
// Depends on cpjr_pkg.
module cpjr_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cpjr_pkg::REG_IDX_W-1:0]      cfg_index_i,
  input  logic [cpjr_pkg::VALUE_W-1:0]        cfg_wdata_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [cpjr_pkg::UFIELD_W-1:0]       time_step_i,
  input  logic signed [cpjr_pkg::VALUE_W-1:0] measured_position_i,
  input  logic signed [cpjr_pkg::VALUE_W-1:0] measured_speed_i,
  input  logic [cpjr_pkg::ACTION_W-1:0]       action_i,
  input  logic                                load_target_i,
  input  logic signed [cpjr_pkg::VALUE_W-1:0] new_position_target_i,
  input  logic signed [cpjr_pkg::VALUE_W-1:0] ramp_rate_i,
  input  logic signed [cpjr_pkg::VALUE_W-1:0] speed_command_i,
  input  logic                                clear_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic signed [cpjr_pkg::VALUE_W-1:0] drive_force_i,
  input  logic                                position_clamped_i,
  input  logic                                speed_clamped_i,
  output int                                  mismatch_count_o,
  output int                                  outstanding_o
);
  import cpjr_pkg::*;

  typedef struct {
    value_t drive_force;
    logic   position_clamped;
    logic   speed_clamped;
  } force_result_t;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -SAT_HI - 1;

  // Gains, caps and loop state, all held in wide signed form
  longint pos_kp, pos_ki, spd_kp, spd_ki, pos_cap, spd_cap, ff_gain;
  longint pos_target, pos_err_sum, spd_err_sum, prev_force, spd_target;

  force_result_t expected_forces[$];
  int            mismatches;

  // Q16.16 saturating arithmetic
  function automatic longint clip(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic longint qadd(longint a, longint b);
    return clip(a + b);
  endfunction

  function automatic longint qsub(longint a, longint b);
    return clip(a - b);
  endfunction

  // exact product, then truncate toward zero
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    if (p < 0) return clip(-((-p) >>> FRAC_W));
    return clip(p >>> FRAC_W);
  endfunction

  // One control step: updates the loop state, returns the expected result
  function automatic force_result_t regulate(longint dt, longint pos, longint spd,
                                             logic [ACTION_W-1:0] act, logic ld,
                                             longint tgt_in, longint rate, longint cmd,
                                             logic clr);
    force_result_t r;
    longint err;
    longint force_now;
    r.position_clamped = 1'b0;
    r.speed_clamped    = 1'b0;
    if (clr) begin
      pos_target  = 0;
      pos_err_sum = 0;
      spd_err_sum = 0;
      prev_force  = 0;
      spd_target  = 0;
    end
    if (ld) pos_target = tgt_in;
    if (act[ACT_RAMP]) pos_target = qadd(pos_target, qmul(rate, dt));

    // outer loop, or the speed command when it is off
    if (act[ACT_POS_ON]) begin
      err = qsub(pos_target, pos);
      pos_err_sum = qadd(pos_err_sum, qmul(err, dt));
      if (pos_err_sum > pos_cap) begin
        pos_err_sum = pos_cap;
        r.position_clamped = 1'b1;
      end else if (pos_err_sum < -pos_cap) begin
        pos_err_sum = -pos_cap;
        r.position_clamped = 1'b1;
      end
      spd_target = qsub(qadd(qmul(pos_kp, err), qmul(pos_ki, pos_err_sum)),
                        qmul(prev_force, ff_gain));
    end else begin
      spd_target = cmd;
    end

    // inner loop; a zero cap means no clamping
    err = qsub(spd_target, spd);
    spd_err_sum = qadd(spd_err_sum, qmul(err, dt));
    if (spd_cap != 0) begin
      if (spd_err_sum > spd_cap) begin
        spd_err_sum = spd_cap;
        r.speed_clamped = 1'b1;
      end else if (spd_err_sum < -spd_cap) begin
        spd_err_sum = -spd_cap;
        r.speed_clamped = 1'b1;
      end
    end
    force_now = qadd(qmul(spd_kp, err), qmul(spd_ki, spd_err_sum));
    prev_force = force_now;
    r.drive_force = value_t'(force_now);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    force_result_t oldest;
    force_result_t fresh;
    if (!rst_ni) begin
      pos_kp      = 65536;
      pos_ki      = 0;
      spd_kp      = 65536;
      spd_ki      = 0;
      pos_cap     = SAT_HI;
      spd_cap     = 0;
      ff_gain     = 0;
      pos_target  = 0;
      pos_err_sum = 0;
      spd_err_sum = 0;
      prev_force  = 0;
      spd_target  = 0;
      mismatches  = 0;
      expected_forces.delete();
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
    end else begin
      // register writes; unknown index is ignored
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_POS_KP:  pos_kp  = $signed(cfg_wdata_i);
          REG_POS_KI:  pos_ki  = $signed(cfg_wdata_i);
          REG_SPD_KP:  spd_kp  = $signed(cfg_wdata_i);
          REG_SPD_KI:  spd_ki  = $signed(cfg_wdata_i);
          REG_POS_CAP: pos_cap = cfg_wdata_i[UFIELD_W-1:0];
          REG_SPD_CAP: spd_cap = cfg_wdata_i[UFIELD_W-1:0];
          REG_FF_GAIN: ff_gain = $signed(cfg_wdata_i);
          default: ;
        endcase
      end

      // accepted input item, queued at the tail
      if (in_valid_i && in_ready_i) begin
        fresh = regulate(time_step_i, measured_position_i, measured_speed_i, action_i,
                         load_target_i, new_position_target_i, ramp_rate_i,
                         speed_command_i, clear_i);
        expected_forces.insert(expected_forces.size(), fresh);
      end

      // accepted result item
      if (out_valid_i && out_ready_i) begin
        if (expected_forces.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, actual drive_force %0d",
                   $time, drive_force_i);
        end else begin
          oldest = expected_forces.pop_front();
          if (drive_force_i !== oldest.drive_force) begin
            mismatches++;
            $display("%0t: drive_force: expected %0d, actual %0d",
                     $time, oldest.drive_force, drive_force_i);
          end
          if (position_clamped_i !== oldest.position_clamped) begin
            mismatches++;
            $display("%0t: position_clamped: expected %0b, actual %0b",
                     $time, oldest.position_clamped, position_clamped_i);
          end
          if (speed_clamped_i !== oldest.speed_clamped) begin
            mismatches++;
            $display("%0t: speed_clamped: expected %0b, actual %0b",
                     $time, oldest.speed_clamped, speed_clamped_i);
          end
        end
      end

      mismatch_count_o <= mismatches;
      outstanding_o    <= expected_forces.size();
    end
  end

endmodule

// ===== verif/tb_cascaded_pi_joint_regulator.sv =====
// Top of the regulator testbench: clock, reset, register settings and item stimulus.
// Depends on cpjr_pkg, cascaded_pi_joint_regulator and cpjr_checker (scoreboard).
module tb_cascaded_pi_joint_regulator;
  import cpjr_pkg::*;

  localparam int                   CYCLE_LIMIT  = 500000;
  localparam int                   DRAIN_CYCLES = 40;
  localparam int                   PHASE_ITEMS  = 200;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED   = 3'd7;

  localparam logic [ACTION_W-1:0] ACT_NONE = '0;
  localparam logic [ACTION_W-1:0] ACT_RAMP_ONLY = ACTION_W'(1 << ACT_RAMP);
  localparam logic [ACTION_W-1:0] ACT_LOOP_ONLY = ACTION_W'(1 << ACT_POS_ON);
  localparam logic [ACTION_W-1:0] ACT_BOTH = ACT_RAMP_ONLY | ACT_LOOP_ONLY;

  localparam value_t VAL_MAX = 32'sh7FFF_FFFF;
  localparam value_t VAL_MIN = 32'sh8000_0000;
  localparam value_t ONE     = 32'sh0001_0000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]   cfg_index = '0;
  logic [VALUE_W-1:0]     cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  ufield_t                time_step = '0;
  value_t                 measured_position = '0;
  value_t                 measured_speed = '0;
  logic [ACTION_W-1:0]    action = '0;
  logic                   load_target = 1'b0;
  value_t                 new_position_target = '0;
  value_t                 ramp_rate = '0;
  value_t                 speed_command = '0;
  logic                   clear = 1'b0;
  logic                   out_ready = 1'b0;
  logic                   quiet = 1'b0;

  logic                   in_ready;
  logic                   out_valid;
  value_t                 drive_force;
  logic                   position_clamped;
  logic                   speed_clamped;
  int                     mismatch_count;
  int                     outstanding;
  int                     cycles = 0;

  cascaded_pi_joint_regulator u_dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_we_i              (cfg_we),
    .cfg_index_i           (cfg_index),
    .cfg_wdata_i           (cfg_wdata),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready),
    .time_step_i           (time_step),
    .measured_position_i   (measured_position),
    .measured_speed_i      (measured_speed),
    .action_i              (action),
    .load_target_i         (load_target),
    .new_position_target_i (new_position_target),
    .ramp_rate_i           (ramp_rate),
    .speed_command_i       (speed_command),
    .clear_i               (clear),
    .out_valid_o           (out_valid),
    .out_ready_i           (out_ready),
    .drive_force_o         (drive_force),
    .position_clamped_o    (position_clamped),
    .speed_clamped_o       (speed_clamped)
  );

  cpjr_checker u_checker (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_we_i              (cfg_we),
    .cfg_index_i           (cfg_index),
    .cfg_wdata_i           (cfg_wdata),
    .in_valid_i            (in_valid),
    .in_ready_i            (in_ready),
    .time_step_i           (time_step),
    .measured_position_i   (measured_position),
    .measured_speed_i      (measured_speed),
    .action_i              (action),
    .load_target_i         (load_target),
    .new_position_target_i (new_position_target),
    .ramp_rate_i           (ramp_rate),
    .speed_command_i       (speed_command),
    .clear_i               (clear),
    .out_valid_i           (out_valid),
    .out_ready_i           (out_ready),
    .drive_force_i         (drive_force),
    .position_clamped_i    (position_clamped),
    .speed_clamped_i       (speed_clamped),
    .mismatch_count_o      (mismatch_count),
    .outstanding_o         (outstanding)
  );

  always #5 clk = ~clk;

  // Watchdog
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // Result side backpressure: random ready and stall bursts, always ready when quiet
  initial begin : result_ready
    forever begin
      if (quiet || $urandom_range(0, 2) != 0) out_ready <= 1'b1;
      else out_ready <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // value spread evenly over [-span, span]
  function automatic value_t near(int span);
    return value_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Drive one item, optionally after an idle burst, and wait for its accept
  task automatic send_item(input ufield_t ts, input value_t pos, input value_t spd,
                           input logic [ACTION_W-1:0] act, input logic ld,
                           input value_t tgt, input value_t rate, input value_t cmd,
                           input logic clr);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid            <= 1'b1;
    time_step           <= ts;
    measured_position   <= pos;
    measured_speed      <= spd;
    action              <= act;
    load_target         <= ld;
    new_position_target <= tgt;
    ramp_rate           <= rate;
    speed_command       <= cmd;
    clear               <= clr;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly plausible servo traffic, the rest full-range noise
  task automatic send_random();
    if ($urandom_range(0, 3) != 0) begin
      send_item(ufield_t'($urandom_range(16, 6554)), near(1 << 19), near(1 << 20),
                ACTION_W'($urandom_range(0, 3)), $urandom_range(0, 3) == 0,
                near(1 << 19), near(1 << 18), near(1 << 20), $urandom_range(0, 39) == 0);
    end else begin
      send_item(ufield_t'($urandom), $urandom, $urandom, ACTION_W'($urandom_range(0, 3)),
                1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                1'($urandom_range(0, 1)));
    end
  endtask

  // Wait until every result is back, then let the sequencer settle
  task automatic wait_idle();
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [REG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Write every register, plus a stray write to the unused index
  task automatic load_settings(input value_t pkp, input value_t pki, input value_t skp,
                               input value_t ski, input logic [VALUE_W-1:0] pcap,
                               input logic [VALUE_W-1:0] scap, input value_t ffg);
    put_reg(REG_POS_KP, pkp);
    put_reg(REG_POS_KI, pki);
    put_reg(REG_SPD_KP, skp);
    put_reg(REG_SPD_KI, ski);
    put_reg(REG_POS_CAP, pcap);
    put_reg(REG_SPD_CAP, scap);
    put_reg(REG_FF_GAIN, ffg);
    put_reg(REG_UNUSED, $urandom);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int count);
    for (int n = 0; n < count; n++) send_random();
    in_valid <= 1'b0;
    wait_idle();
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items under reset defaults: zero, extremes, each action, load, clear
    send_item('0, '0, '0, ACT_NONE, 1'b0, '0, '0, '0, 1'b0);
    send_item('1, VAL_MAX, VAL_MIN, ACT_BOTH, 1'b1, VAL_MAX, VAL_MAX, VAL_MAX, 1'b0);
    send_item('1, VAL_MIN, VAL_MAX, ACT_BOTH, 1'b1, VAL_MIN, VAL_MIN, VAL_MIN, 1'b0);
    send_item('1, VAL_MAX, VAL_MAX, ACT_NONE, 1'b0, '0, '0, VAL_MIN, 1'b0);
    send_item('1, '0, '0, ACT_RAMP_ONLY, 1'b0, '0, VAL_MIN, '0, 1'b1);
    send_item(ufield_t'(ONE), ONE, '0, ACT_LOOP_ONLY, 1'b0, '0, '0, '0, 1'b0);
    send_item(ufield_t'(ONE), '0, ONE, ACT_NONE, 1'b1, 3 * ONE, '0, -ONE, 1'b0);
    send_item(ufield_t'(ONE), '0, '0, ACT_LOOP_ONLY, 1'b0, '0, '0, '0, 1'b0);
    send_item(ufield_t'(ONE >> 4), '0, '0, ACT_RAMP_ONLY, 1'b0, '0, 2 * ONE, '0, 1'b0);
    send_item(ufield_t'(ONE >> 4), '0, '0, ACT_BOTH, 1'b0, '0, 2 * ONE, '0, 1'b0);
    send_item('0, ONE, -ONE, ACT_BOTH, 1'b1, -ONE, ONE, '0, 1'b1);
    send_item(ufield_t'(ONE), ONE, ONE, ACT_BOTH, 1'b1, 5 * ONE, -ONE, ONE, 1'b1);
    send_item(ufield_t'(ONE), '0, '0, ACT_NONE, 1'b0, '0, '0, '0, 1'b1);
    in_valid <= 1'b0;
    wait_idle();

    // Small caps with unit gains and feedback: both clamp flags, both signs
    load_settings(ONE, ONE, ONE, ONE, 32'h0000_0100, 32'h0000_0100, ONE >>> 1);
    send_item(ufield_t'(ONE), '0, '0, ACT_BOTH, 1'b1, 4 * ONE, '0, '0, 1'b1);
    send_item(ufield_t'(ONE), '0, '0, ACT_LOOP_ONLY, 1'b1, -4 * ONE, '0, '0, 1'b0);
    send_item(ufield_t'(ONE), '0, 2 * ONE, ACT_NONE, 1'b0, '0, '0, -ONE, 1'b0);
    send_item(ufield_t'(ONE), '0, -ONE, ACT_NONE, 1'b0, '0, '0, ONE, 1'b0);
    send_item(ufield_t'(ONE >> 12), '0, '0, ACT_LOOP_ONLY, 1'b1, ONE >>> 8, '0, '0, 1'b1);
    send_item(ufield_t'(ONE), VAL_MIN, VAL_MIN, ACT_LOOP_ONLY, 1'b1, VAL_MAX, '0, '0, 1'b0);
    in_valid <= 1'b0;
    wait_idle();

    // Moderate gains and caps
    load_settings(value_t'($urandom_range(1 << 14, 1 << 18)), value_t'($urandom_range(0, 1 << 17)),
                  value_t'($urandom_range(1 << 14, 1 << 18)), value_t'($urandom_range(0, 1 << 17)),
                  $urandom_range(1 << 16, 1 << 20), $urandom_range(1 << 16, 1 << 20),
                  near(1 << 14));
    run_phase(PHASE_ITEMS);

    // Tight caps so the integrals clamp often
    load_settings(value_t'($urandom_range(1 << 14, 1 << 18)), value_t'($urandom_range(0, 1 << 17)),
                  value_t'($urandom_range(1 << 14, 1 << 18)), value_t'($urandom_range(0, 1 << 17)),
                  $urandom_range(0, 1 << 12), $urandom_range(1, 1 << 12), near(1 << 15));
    run_phase(PHASE_ITEMS);

    // Largest values everywhere; bit 31 of the caps is dropped
    load_settings(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, '1, '1, VAL_MAX);
    run_phase(PHASE_ITEMS);

    // Most negative gains with zero caps
    load_settings(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, 32'h8000_0000, '0, VAL_MIN);
    run_phase(PHASE_ITEMS);

    // Fully random registers
    load_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    run_phase(PHASE_ITEMS);

    // Negative moderate gains, speed clamp off, no idling on either side
    quiet <= 1'b1;
    load_settings(-value_t'($urandom_range(1 << 14, 1 << 18)), -value_t'($urandom_range(0, 1 << 17)),
                  -value_t'($urandom_range(1 << 14, 1 << 18)), -value_t'($urandom_range(0, 1 << 17)),
                  $urandom_range(1 << 16, 1 << 20), '0, near(1 << 14));
    run_phase(PHASE_ITEMS);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
